// ----- design/v3a_pkg.sv -----
package v3a_pkg;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int OW = DW + 1;
  localparam int PW = 2 * OW;
  localparam int SW = PW + 2;
  localparam int RW = SW / 2;
  localparam int RMW = RW + 2;

  localparam logic signed [SW-1:0] SMAX = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_SCALE  = 4'd2,
    OP_MIN    = 4'd3,
    OP_MAX    = 4'd4,
    OP_ABS    = 4'd5,
    OP_DOT    = 4'd6,
    OP_CROSS  = 4'd7,
    OP_NORMSQ = 4'd8,
    OP_DISTSQ = 4'd9,
    OP_ZERO   = 4'd10,
    OP_EQUAL  = 4'd11,
    OP_NORM   = 4'd12,
    OP_DIST   = 4'd13
  } op_t;

  typedef struct packed {
    logic [3:0]             operation;
    logic signed [DW-1:0]   a_x;
    logic signed [DW-1:0]   a_y;
    logic signed [DW-1:0]   a_z;
    logic signed [DW-1:0]   b_x;
    logic signed [DW-1:0]   b_y;
    logic signed [DW-1:0]   b_z;
    logic signed [DW-1:0]   scalar_in;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] res_x;
    logic signed [DW-1:0] res_y;
    logic signed [DW-1:0] res_z;
    logic signed [DW-1:0] res_scalar;
    logic                 res_flag;
    logic                 saturated;
  } out_t;

  typedef struct packed {
    op_t                  op;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] aj;
    logic signed [DW-1:0] bk;
    logic signed [DW-1:0] ak;
    logic signed [DW-1:0] bj;
    logic signed [DW-1:0] s;
  } lane_in_t;

  typedef struct packed {
    logic signed [SW-1:0] t;
    logic signed [DW-1:0] v;
    logic                 vsat;
    logic                 zero;
    logic                 eq;
  } lane_out_t;

  typedef struct packed {
    logic signed [DW-1:0] res_x;
    logic signed [DW-1:0] res_y;
    logic signed [DW-1:0] res_z;
    logic signed [DW-1:0] res_scalar;
    logic                 res_flag;
    logic                 saturated;
    logic                 is_root;
  } sb_t;

  typedef struct packed {
    logic signed [DW-1:0] val;
    logic                 hit;
  } sat_t;

  function automatic sat_t sat_w(input logic signed [SW-1:0] v);
    sat_t r;
    if (v > SMAX) begin
      r.val = SMAX[DW-1:0];
      r.hit = 1'b1;
    end else if (v < SMIN) begin
      r.val = SMIN[DW-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[DW-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- design/v3a_lane.sv -----
module v3a_lane (
  input  logic               clk,
  input  logic               en,
  input  v3a_pkg::lane_in_t  li,
  output v3a_pkg::lane_out_t lo
);
  import v3a_pkg::*;

  logic signed [OW-1:0] a_e, b_e, d_e, sum_e, abs_e;
  logic signed [OW-1:0] m0a_nxt, m0b_nxt, m1a_nxt, m1b_nxt;
  logic signed [DW-1:0] v_nxt;
  logic                 vsat_nxt;
  sat_t                 st;

  logic signed [OW-1:0] m0a_r, m0b_r, m1a_r, m1b_r;
  logic signed [DW-1:0] v1_r, v2_r, v3_r;
  logic                 vsat1_r, vsat2_r, vsat3_r;
  logic                 zero1_r, zero2_r, zero3_r;
  logic                 eq1_r, eq2_r, eq3_r;
  logic signed [PW-1:0] p0_r, p1_r;
  logic signed [SW-1:0] t_r;

  always_comb begin
    a_e   = {li.a[DW-1], li.a};
    b_e   = {li.b[DW-1], li.b};
    d_e   = a_e - b_e;
    sum_e = a_e + b_e;
    abs_e = a_e[OW-1] ? -a_e : a_e;
    m0a_nxt = '0;
    m0b_nxt = '0;
    m1a_nxt = '0;
    m1b_nxt = '0;
    v_nxt = '0;
    vsat_nxt = 1'b0;
    st = '0;
    unique case (li.op)
      OP_ADD: st = sat_w({{(SW-OW){sum_e[OW-1]}}, sum_e});
      OP_SUB: st = sat_w({{(SW-OW){d_e[OW-1]}}, d_e});
      OP_ABS: st = sat_w({{(SW-OW){abs_e[OW-1]}}, abs_e});
      OP_MIN: st.val = (li.a >= li.b) ? li.b : li.a;
      OP_MAX: st.val = (li.a >= li.b) ? li.a : li.b;
      OP_SCALE: begin
        m0a_nxt = a_e;
        m0b_nxt = {li.s[DW-1], li.s};
      end
      OP_DOT: begin
        m0a_nxt = a_e;
        m0b_nxt = b_e;
      end
      OP_NORMSQ, OP_NORM: begin
        m0a_nxt = a_e;
        m0b_nxt = a_e;
      end
      OP_DISTSQ, OP_DIST: begin
        m0a_nxt = d_e;
        m0b_nxt = d_e;
      end
      OP_CROSS: begin
        m0a_nxt = {li.aj[DW-1], li.aj};
        m0b_nxt = {li.bk[DW-1], li.bk};
        m1a_nxt = {li.ak[DW-1], li.ak};
        m1b_nxt = {li.bj[DW-1], li.bj};
      end
      default: st = '0;
    endcase
    v_nxt = st.val;
    vsat_nxt = st.hit;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0a_r   <= m0a_nxt;
      m0b_r   <= m0b_nxt;
      m1a_r   <= m1a_nxt;
      m1b_r   <= m1b_nxt;
      v1_r    <= v_nxt;
      vsat1_r <= vsat_nxt;
      zero1_r <= (li.a == '0);
      eq1_r   <= (li.a == li.b);
      p0_r    <= m0a_r * m0b_r;
      p1_r    <= m1a_r * m1b_r;
      v2_r    <= v1_r;
      vsat2_r <= vsat1_r;
      zero2_r <= zero1_r;
      eq2_r   <= eq1_r;
      t_r     <= {{(SW-PW){p0_r[PW-1]}}, p0_r} - {{(SW-PW){p1_r[PW-1]}}, p1_r};
      v3_r    <= v2_r;
      vsat3_r <= vsat2_r;
      zero3_r <= zero2_r;
      eq3_r   <= eq2_r;
    end
  end

  assign lo.t    = t_r;
  assign lo.v    = v3_r;
  assign lo.vsat = vsat3_r;
  assign lo.zero = zero3_r;
  assign lo.eq   = eq3_r;

endmodule

// ----- design/v3a_isqrt.sv -----
module v3a_isqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [v3a_pkg::SW-1:0] rad,
  input  v3a_pkg::sb_t       in_sb,
  output logic               out_vld,
  output logic [v3a_pkg::RW-1:0] root,
  output v3a_pkg::sb_t       out_sb
);
  import v3a_pkg::*;

  logic [SW-1:0]  rad_r  [RW];
  logic [RMW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  sb_t            sb_r   [RW];
  logic [RW-1:0]  vld_r;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [SW-1:0]  rad_i;
    logic [RMW-1:0] rem_i;
    logic [RW-1:0]  root_i;
    sb_t            sb_i;
    logic           vld_i;
    logic [RMW-1:0] cur, trial;

    if (k == 0) begin : g_first
      assign rad_i  = rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign sb_i   = in_sb;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign sb_i   = sb_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    assign cur   = {rem_i[RMW-3:0], rad_i[SW-1:SW-2]};
    assign trial = {root_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k] <= rad_i << 2;
        sb_r[k]  <= sb_i;
        if (cur >= trial) begin
          rem_r[k]  <= cur - trial;
          root_r[k] <= {root_i[RW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= cur;
          root_r[k] <= {root_i[RW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end
  end

  assign out_vld = vld_r[RW-1];
  assign root    = root_r[RW-1];
  assign out_sb  = sb_r[RW-1];

endmodule

// ----- design/vec3_fixed_point_alu_top.sv -----
// Channel | Ports                        | Moves
// in      | in_valid, in_ready, in_data   | one operation with vectors a, b and scalar
// out     | out_valid, out_ready, out_data | one result item per transfer
//
// One item per cycle sustained while the output is not stalled.
// The root unit produces one result bit per stage over 34 stages.
// rst_n is synchronous and clears all valid bits.
// A stalled output freezes the whole pipeline; in_ready stays high while out is empty
// or being taken.
module vec3_fixed_point_alu_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  v3a_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output v3a_pkg::out_t out_data
);
  import v3a_pkg::*;

  logic      en;
  lane_in_t  li [3];
  lane_out_t lo [3];
  logic signed [DW-1:0] av [3];
  logic signed [DW-1:0] bv [3];
  logic [3:0] vld_r;
  op_t        op_r [4];

  logic signed [SW-1:0] t4_r [3];
  logic signed [SW-1:0] sum4_r;
  logic signed [DW-1:0] v4_r [3];
  logic                 vsat4_r, zero4_r, eq4_r;

  sb_t            sb_nxt;
  sat_t           s_sum, s_t0, s_t1, s_t2, s_root;
  logic           q_vld;
  logic [RW-1:0]  q_root;
  sb_t            q_sb;
  out_t           out_r, out_nxt;
  logic           out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign av[0] = in_data.a_x;
  assign av[1] = in_data.a_y;
  assign av[2] = in_data.a_z;
  assign bv[0] = in_data.b_x;
  assign bv[1] = in_data.b_y;
  assign bv[2] = in_data.b_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign li[i].op = op_t'(in_data.operation);
    assign li[i].a  = av[i];
    assign li[i].b  = bv[i];
    assign li[i].aj = av[(i+1)%3];
    assign li[i].bk = bv[(i+2)%3];
    assign li[i].ak = av[(i+2)%3];
    assign li[i].bj = bv[(i+1)%3];
    assign li[i].s  = in_data.scalar_in;

    v3a_lane u_lane (
      .clk (clk),
      .en  (en),
      .li  (li[i]),
      .lo  (lo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0] <= op_t'(in_data.operation);
      op_r[1] <= op_r[0];
      op_r[2] <= op_r[1];
      op_r[3] <= op_r[2];
      for (int i = 0; i < 3; i++) begin
        t4_r[i] <= lo[i].t;
        v4_r[i] <= lo[i].v;
      end
      sum4_r  <= lo[0].t + lo[1].t + lo[2].t;
      vsat4_r <= lo[0].vsat | lo[1].vsat | lo[2].vsat;
      zero4_r <= lo[0].zero & lo[1].zero & lo[2].zero;
      eq4_r   <= lo[0].eq & lo[1].eq & lo[2].eq;
    end
  end

  always_comb begin
    s_sum = sat_w(sum4_r >>> FB);
    s_t0  = sat_w(t4_r[0] >>> FB);
    s_t1  = sat_w(t4_r[1] >>> FB);
    s_t2  = sat_w(t4_r[2] >>> FB);
    sb_nxt = '0;
    unique case (op_r[3])
      OP_ADD, OP_SUB, OP_MIN, OP_MAX, OP_ABS: begin
        sb_nxt.res_x     = v4_r[0];
        sb_nxt.res_y     = v4_r[1];
        sb_nxt.res_z     = v4_r[2];
        sb_nxt.saturated = vsat4_r;
      end
      OP_SCALE, OP_CROSS: begin
        sb_nxt.res_x     = s_t0.val;
        sb_nxt.res_y     = s_t1.val;
        sb_nxt.res_z     = s_t2.val;
        sb_nxt.saturated = s_t0.hit | s_t1.hit | s_t2.hit;
      end
      OP_DOT, OP_NORMSQ, OP_DISTSQ: begin
        sb_nxt.res_scalar = s_sum.val;
        sb_nxt.saturated  = s_sum.hit;
      end
      OP_ZERO:  sb_nxt.res_flag = zero4_r;
      OP_EQUAL: sb_nxt.res_flag = eq4_r;
      OP_NORM, OP_DIST: sb_nxt.is_root = 1'b1;
      default: sb_nxt = '0;
    endcase
  end

  v3a_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_r[3]),
    .rad     (sum4_r),
    .in_sb   (sb_nxt),
    .out_vld (q_vld),
    .root    (q_root),
    .out_sb  (q_sb)
  );

  always_comb begin
    s_root = sat_w({{(SW-RW){1'b0}}, q_root});
    out_nxt.res_x      = q_sb.res_x;
    out_nxt.res_y      = q_sb.res_y;
    out_nxt.res_z      = q_sb.res_z;
    out_nxt.res_flag   = q_sb.res_flag;
    out_nxt.res_scalar = q_sb.is_root ? s_root.val : q_sb.res_scalar;
    out_nxt.saturated  = q_sb.is_root ? s_root.hit : q_sb.saturated;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/v3a_chk.sv -----
module v3a_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input v3a_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input v3a_pkg::out_t out_data
);
  import v3a_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input held off with empty output");

  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.res_flag |-> out_data.res_x == '0 && out_data.res_y == '0
      && out_data.res_z == '0 && out_data.res_scalar == '0 && !out_data.saturated)
    else $error("flag result carries other fields");

endmodule

bind vec3_fixed_point_alu_top v3a_chk u_chk (.*);
